@@ design/i2a_pkg.sv @@
// i2a_pkg: shared types, codes and character helpers for the integer to ascii formatter
// no dependencies; used by i2a_dabble and integer_to_ascii_formatter
package i2a_pkg;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned DecDigs = 20;
  localparam int unsigned BcdW    = 4 * DecDigs;
  localparam int unsigned CharW   = 7;
  localparam int unsigned CntW    = 7;

  localparam logic [2:0] OP_SDEC   = 3'd0;
  localparam logic [2:0] OP_UDEC   = 3'd1;
  localparam logic [2:0] OP_HEX    = 3'd2;
  localparam logic [2:0] OP_HEX0X  = 3'd3;
  localparam logic [2:0] OP_HEX16  = 3'd4;
  localparam logic [2:0] OP_BIN    = 3'd5;
  localparam logic [2:0] OP_BIN64  = 3'd6;

  localparam logic [CntW-1:0] CONV_STEPS = CntW'(ValueW);
  localparam logic [CntW-1:0] DEC_CNT    = CntW'(DecDigs);
  localparam logic [CntW-1:0] HEX_CNT    = CntW'(ValueW / 4);
  localparam logic [CntW-1:0] BIN_CNT    = CntW'(ValueW);

  localparam logic [CharW-1:0] CH_MINUS = 7'h2d;
  localparam logic [CharW-1:0] CH_ZERO  = 7'h30;
  localparam logic [CharW-1:0] CH_X     = 7'h78;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MINUS = 7'b0000010,
    S_ZERO  = 7'b0000100,
    S_X     = 7'b0001000,
    S_CONV  = 7'b0010000,
    S_SKIP  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] d);
    logic [CharW-1:0] c;
    case (d)
      4'd0:  c = 7'h30;
      4'd1:  c = 7'h31;
      4'd2:  c = 7'h32;
      4'd3:  c = 7'h33;
      4'd4:  c = 7'h34;
      4'd5:  c = 7'h35;
      4'd6:  c = 7'h36;
      4'd7:  c = 7'h37;
      4'd8:  c = 7'h38;
      4'd9:  c = 7'h39;
      4'd10: c = 7'h61;
      4'd11: c = 7'h62;
      4'd12: c = 7'h63;
      4'd13: c = 7'h64;
      4'd14: c = 7'h65;
      default: c = 7'h66;
    endcase
    return c;
  endfunction

endpackage

@@ design/integer_to_ascii_formatter.sv @@
// integer_to_ascii_formatter: top level, sequencer and output register
// depends on i2a_pkg and i2a_dabble
//
// One item is taken while the block is idle; in_stall_o stays high until the last
// character of that item sits in the output register. Decimal modes run a
// shift-and-add-3 unit over every bit of the value, drop leading zero digits
// one per cycle, then send one character per cycle while the output is not stalled;
// skipped and sent digits always add up to 20, and a negative signed value sends a
// minus sign first. Minimal hex and minimal binary skip leading zeros one digit per
// cycle and then send one character per cycle while the output is not stalled; the
// 0x and fixed hex modes send a 0x prefix first, and fixed hex and fixed binary skip
// nothing. An output stall while a character waits holds the sequencer. Selector
// seven yields no characters and the block stays idle.
module integer_to_ascii_formatter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   op_i,
  input  logic [i2a_pkg::ValueW-1:0]   value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [i2a_pkg::CharW-1:0]    out_char_o,
  output logic                         last_char_o
);

  i2a_pkg::state_e state_q, state_d;
  logic [i2a_pkg::BcdW-1:0]   d_q, d_d;
  logic [i2a_pkg::ValueW-1:0] w_q, w_d;
  logic [i2a_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                       wide_q, wide_d;
  logic                       fix_q, fix_d;
  logic                       ov_q, ov_d;
  logic [i2a_pkg::CharW-1:0]  oc_q, oc_d;
  logic                       ol_q, ol_d;

  logic [i2a_pkg::BcdW-1:0]   dab_bcd;
  logic [i2a_pkg::ValueW-1:0] dab_bin;
  logic                       slot_free;
  logic                       load;
  logic [3:0]                 dig;
  logic [i2a_pkg::BcdW-1:0]   d_shift;

  i2a_dabble u_dabble (
    .bcd_i (d_q),
    .bin_i (w_q),
    .bcd_o (dab_bcd),
    .bin_o (dab_bin)
  );

  assign slot_free = !ov_q || !out_stall_i;
  assign dig       = wide_q ? d_q[i2a_pkg::BcdW-1 -: 4] : {3'b000, d_q[i2a_pkg::BcdW-1]};
  assign d_shift   = wide_q ? {d_q[i2a_pkg::BcdW-5:0], 4'b0000}
                            : {d_q[i2a_pkg::BcdW-2:0], 1'b0};

  always_comb begin
    state_d = state_q;
    d_d     = d_q;
    w_d     = w_q;
    cnt_d   = cnt_q;
    wide_d  = wide_q;
    fix_d   = fix_q;
    load    = 1'b0;
    oc_d    = oc_q;
    ol_d    = 1'b0;
    unique case (state_q)
      i2a_pkg::S_IDLE: begin
        if (in_valid_i) begin
          w_d    = value_i;
          d_d    = {value_i, 16'h0000};
          wide_d = 1'b1;
          fix_d  = 1'b0;
          case (op_i)
            i2a_pkg::OP_SDEC: begin
              d_d   = '0;
              cnt_d = i2a_pkg::CONV_STEPS;
              if (value_i[i2a_pkg::ValueW-1]) begin
                w_d     = ~value_i + 64'd1;
                state_d = i2a_pkg::S_MINUS;
              end else begin
                state_d = i2a_pkg::S_CONV;
              end
            end
            i2a_pkg::OP_UDEC: begin
              d_d     = '0;
              cnt_d   = i2a_pkg::CONV_STEPS;
              state_d = i2a_pkg::S_CONV;
            end
            i2a_pkg::OP_HEX: begin
              cnt_d   = i2a_pkg::HEX_CNT;
              state_d = i2a_pkg::S_SKIP;
            end
            i2a_pkg::OP_HEX0X: begin
              cnt_d   = i2a_pkg::HEX_CNT;
              state_d = i2a_pkg::S_ZERO;
            end
            i2a_pkg::OP_HEX16: begin
              cnt_d   = i2a_pkg::HEX_CNT;
              fix_d   = 1'b1;
              state_d = i2a_pkg::S_ZERO;
            end
            i2a_pkg::OP_BIN: begin
              cnt_d   = i2a_pkg::BIN_CNT;
              wide_d  = 1'b0;
              state_d = i2a_pkg::S_SKIP;
            end
            i2a_pkg::OP_BIN64: begin
              cnt_d   = i2a_pkg::BIN_CNT;
              wide_d  = 1'b0;
              state_d = i2a_pkg::S_EMIT;
            end
            default: begin
              state_d = i2a_pkg::S_IDLE;
            end
          endcase
        end
      end
      i2a_pkg::S_MINUS: begin
        if (slot_free) begin
          load    = 1'b1;
          oc_d    = i2a_pkg::CH_MINUS;
          state_d = i2a_pkg::S_CONV;
        end
      end
      i2a_pkg::S_ZERO: begin
        if (slot_free) begin
          load    = 1'b1;
          oc_d    = i2a_pkg::CH_ZERO;
          state_d = i2a_pkg::S_X;
        end
      end
      i2a_pkg::S_X: begin
        if (slot_free) begin
          load    = 1'b1;
          oc_d    = i2a_pkg::CH_X;
          state_d = fix_q ? i2a_pkg::S_EMIT : i2a_pkg::S_SKIP;
        end
      end
      i2a_pkg::S_CONV: begin
        d_d   = dab_bcd;
        w_d   = dab_bin;
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          cnt_d   = i2a_pkg::DEC_CNT;
          wide_d  = 1'b1;
          state_d = i2a_pkg::S_SKIP;
        end
      end
      i2a_pkg::S_SKIP: begin
        if ((cnt_q > 7'd1) && (dig == 4'd0)) begin
          d_d   = d_shift;
          cnt_d = cnt_q - 7'd1;
        end else begin
          state_d = i2a_pkg::S_EMIT;
        end
      end
      i2a_pkg::S_EMIT: begin
        if (slot_free) begin
          load  = 1'b1;
          oc_d  = i2a_pkg::hex_char(dig);
          ol_d  = (cnt_q == 7'd1);
          d_d   = d_shift;
          cnt_d = cnt_q - 7'd1;
          if (cnt_q == 7'd1) begin
            state_d = i2a_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = i2a_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      ov_d = 1'b1;
    end else if (!out_stall_i) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2a_pkg::S_IDLE;
      cnt_q   <= '0;
      wide_q  <= 1'b0;
      fix_q   <= 1'b0;
      ov_q    <= 1'b0;
      w_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wide_q  <= wide_d;
      fix_q   <= fix_d;
      ov_q    <= ov_d;
      w_q     <= w_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;
    if (load) begin
      oc_q <= oc_d;
      ol_q <= ol_d;
    end
  end

  assign in_stall_o  = (state_q != i2a_pkg::S_IDLE);
  assign out_valid_o = ov_q;
  assign out_char_o  = oc_q;
  assign last_char_o = ol_q;

endmodule

@@ design/i2a_dabble.sv @@
// i2a_dabble: one shift-and-add-3 step of binary to bcd conversion
// depends on i2a_pkg for widths
module i2a_dabble (
  input  logic [i2a_pkg::BcdW-1:0]   bcd_i,
  input  logic [i2a_pkg::ValueW-1:0] bin_i,
  output logic [i2a_pkg::BcdW-1:0]   bcd_o,
  output logic [i2a_pkg::ValueW-1:0] bin_o
);

  logic [i2a_pkg::BcdW-1:0] adj;

  always_comb begin
    for (int i = 0; i < i2a_pkg::DecDigs; i++) begin
      if (bcd_i[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_i[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_i[4*i +: 4];
      end
    end
  end

  assign bcd_o = {adj[i2a_pkg::BcdW-2:0], bin_i[i2a_pkg::ValueW-1]};
  assign bin_o = {bin_i[i2a_pkg::ValueW-2:0], 1'b0};

endmodule
